### rtl/core/raster_shape_drawer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the raster shape drawer
// Concurrent checks sampled on the rising clock edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef RASTER_SHAPE_DRAWER_MACROS_SVH
`define RASTER_SHAPE_DRAWER_MACROS_SVH

// same-cycle implication
`define RSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Image geometry, coordinate widths, command and state types of the drawer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

  localparam int ROWS   = 32;
  localparam int COLS   = 64;
  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);

  // signed working coordinate: start +/- 8-bit offsets, twice over for rect
  localparam int CRD_W  = 11;

  localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(DEPTH - 1);
  localparam logic signed [CRD_W-1:0] COLS_C = CRD_W'(COLS);
  localparam logic signed [CRD_W-1:0] ROWS_C = CRD_W'(ROWS);

  typedef enum logic [3:0] {
    KIND_FILL      = 4'd0,
    KIND_POINT     = 4'd1,
    KIND_HRUN      = 4'd2,
    KIND_VRUN      = 4'd3,
    KIND_RECT      = 4'd4,
    KIND_DIAG_UP   = 4'd5,
    KIND_DIAG_DOWN = 4'd6,
    KIND_DISC      = 4'd7,
    KIND_READ      = 4'd8
  } kind_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_RUN  = 7'b0000100,
    S_DISC = 7'b0001000,
    S_FILL = 7'b0010000,
    S_READ = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

### rtl/core/raster_shape_drawer.sv
// ----------------------------------------------------------------------------
// raster_shape_drawer
// Character framebuffer drawing engine with clipped cell writes.
// ----------------------------------------------------------------------------
// The image (ROWS x COLS cells of 8 bits) sits in one synchronous RAM with a
// single write port, and every command is processed on its own: the next one
// is taken once the current one has handed its result to the output register.
// The write port sets the rate, one cell a cycle, and cells that fall outside
// the image are still stepped through, unwritten. A read goes through the
// RAM read register and the read state; a kind with no shape writes nothing
// and goes straight to the result. Image contents are undefined until the
// first fill or write.
`timescale 1ns / 1ps
`default_nettype none

`include "raster_shape_drawer_macros.svh"

module raster_shape_drawer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // symbol[7:0], start_col[15:8], start_row[23:16], span[31:24],
  // height[39:32], radius[45:40], zero pad[47:46]
  input  wire logic [47:0] s_axis_tdata,
  // kind[3:0]
  input  wire logic [3:0]  s_axis_tuser,

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // cell_value[7:0]
  output logic [7:0]       m_axis_tdata,
  // cell_valid[0]
  output logic [0:0]       m_axis_tuser
);

  localparam int CW = rsd_pkg::CRD_W;
  localparam int AW = rsd_pkg::ADDR_W;

  // input fields
  logic [3:0]        in_kind;
  logic [7:0]        in_symbol;
  logic signed [7:0] in_col;
  logic signed [7:0] in_row;
  logic [7:0]        in_span;
  logic [7:0]        in_height;
  logic [5:0]        in_radius;
  logic              in_accept;

  assign in_kind   = s_axis_tuser;
  assign in_symbol = s_axis_tdata[7:0];
  assign in_col    = $signed(s_axis_tdata[15:8]);
  assign in_row    = $signed(s_axis_tdata[23:16]);
  assign in_span   = s_axis_tdata[31:24];
  assign in_height = s_axis_tdata[39:32];
  assign in_radius = s_axis_tdata[45:40];

  rsd_pkg::state_e state_q, state_d;

  rsd_pkg::kind_e    kind_q, kind_d;
  logic [7:0]        sym_q, sym_d;
  logic signed [7:0] base_col_q, base_col_d;
  logic signed [7:0] base_row_q, base_row_d;
  logic [7:0]        span_q, span_d;
  logic [7:0]        hgt_q, hgt_d;
  logic [1:0]        seg_q, seg_d;

  // run walker
  logic signed [CW-1:0] cur_col_q, cur_col_d;
  logic signed [CW-1:0] cur_row_q, cur_row_d;
  logic [7:0]           cnt_q, cnt_d;
  logic                 dc_q, dc_d;
  logic signed [1:0]    dr_q, dr_d;

  // disc scan
  logic signed [6:0] dx_q, dx_d;
  logic signed [6:0] dy_q, dy_d;
  logic [5:0]        rad_q, rad_d;
  logic [11:0]       rsq_q, rsq_d;

  logic [AW-1:0] fill_q, fill_d;

  logic [7:0] res_value_q, res_value_d;
  logic       res_valid_q, res_valid_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_value_q, out_value_d;
  logic       out_cvalid_q, out_cvalid_d;

  // image RAM
  logic [7:0]    image_mem [rsd_pkg::DEPTH];
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic          mem_rd_en;
  logic [7:0]    rd_data_q;

  // current cell
  logic signed [CW-1:0] pt_col, pt_row;
  logic                 pt_inside;
  logic [AW-1:0]        pt_addr;

  logic signed [6:0] rad_pos;
  logic [13:0]       dx_sq, dy_sq;
  logic [14:0]       dist_sq;
  logic              in_disc;

  assign s_axis_tready = (state_q == rsd_pkg::S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    unique case (state_q)
      rsd_pkg::S_IDLE: begin
        pt_col = CW'(in_col);
        pt_row = CW'(in_row);
      end
      rsd_pkg::S_DISC: begin
        pt_col = CW'(base_col_q) + CW'(dx_q);
        pt_row = CW'(base_row_q) + CW'(dy_q);
      end
      default: begin
        pt_col = cur_col_q;
        pt_row = cur_row_q;
      end
    endcase
  end

  assign pt_inside = (pt_col >= 0) && (pt_col < rsd_pkg::COLS_C) &&
                     (pt_row >= 0) && (pt_row < rsd_pkg::ROWS_C);
  assign pt_addr   = AW'(pt_row[rsd_pkg::ROW_W-1:0]) * AW'(rsd_pkg::COLS) +
                     AW'(pt_col[rsd_pkg::COL_W-1:0]);

  assign rad_pos = $signed({1'b0, rad_q});
  assign dx_sq   = $unsigned(14'(dx_q) * 14'(dx_q));
  assign dy_sq   = $unsigned(14'(dy_q) * 14'(dy_q));
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign in_disc = (dist_sq <= 15'(rsq_q));

  assign mem_wr_en   = (state_q == rsd_pkg::S_FILL) ||
                       ((state_q == rsd_pkg::S_RUN) && (cnt_q != 8'd0) && pt_inside) ||
                       ((state_q == rsd_pkg::S_DISC) && in_disc && pt_inside);
  assign mem_wr_addr = (state_q == rsd_pkg::S_FILL) ? fill_q : pt_addr;
  assign mem_rd_en   = in_accept && (in_kind == rsd_pkg::KIND_READ) && pt_inside;

  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      image_mem[mem_wr_addr] <= sym_q;
    end
    if (mem_rd_en) begin
      rd_data_q <= image_mem[pt_addr];
    end
  end

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    sym_d        = sym_q;
    base_col_d   = base_col_q;
    base_row_d   = base_row_q;
    span_d       = span_q;
    hgt_d        = hgt_q;
    seg_d        = seg_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    cnt_d        = cnt_q;
    dc_d         = dc_q;
    dr_d         = dr_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    rad_d        = rad_q;
    rsq_d        = rsq_q;
    fill_d       = fill_q;
    res_value_d  = res_value_q;
    res_valid_d  = res_valid_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_cvalid_d = out_cvalid_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      rsd_pkg::S_IDLE: begin
        if (in_accept) begin
          kind_d      = rsd_pkg::kind_e'(in_kind);
          sym_d       = in_symbol;
          base_col_d  = in_col;
          base_row_d  = in_row;
          span_d      = in_span;
          hgt_d       = in_height;
          seg_d       = 2'd0;
          rad_d       = in_radius;
          rsq_d       = {6'd0, in_radius} * {6'd0, in_radius};
          dx_d        = $signed(7'd0 - {1'b0, in_radius});
          dy_d        = $signed(7'd0 - {1'b0, in_radius});
          fill_d      = '0;
          res_value_d = 8'd0;
          res_valid_d = 1'b0;
          case (in_kind)
            rsd_pkg::KIND_FILL: state_d = rsd_pkg::S_FILL;
            rsd_pkg::KIND_POINT, rsd_pkg::KIND_HRUN, rsd_pkg::KIND_VRUN,
            rsd_pkg::KIND_RECT, rsd_pkg::KIND_DIAG_UP,
            rsd_pkg::KIND_DIAG_DOWN: state_d = rsd_pkg::S_LOAD;
            rsd_pkg::KIND_DISC: state_d = rsd_pkg::S_DISC;
            rsd_pkg::KIND_READ: begin
              res_valid_d = pt_inside;
              state_d     = rsd_pkg::S_READ;
            end
            default: state_d = rsd_pkg::S_DONE;
          endcase
        end
      end

      rsd_pkg::S_LOAD: begin
        cur_col_d = CW'(base_col_q);
        cur_row_d = CW'(base_row_q);
        cnt_d     = span_q;
        dc_d      = 1'b1;
        dr_d      = 2'sd0;
        unique case (kind_q)
          rsd_pkg::KIND_POINT: begin
            cnt_d = 8'd1;
            dc_d  = 1'b0;
          end
          rsd_pkg::KIND_VRUN: begin
            dc_d = 1'b0;
            dr_d = 2'sd1;
          end
          rsd_pkg::KIND_DIAG_UP:   dr_d = -2'sd1;
          rsd_pkg::KIND_DIAG_DOWN: dr_d = 2'sd1;
          rsd_pkg::KIND_RECT: begin
            // top, bottom, left, right edges in turn
            case (seg_q)
              2'd1: cur_row_d = CW'(base_row_q) + CW'({1'b0, hgt_q}) - CW'(1);
              2'd2: begin
                cnt_d = hgt_q;
                dc_d  = 1'b0;
                dr_d  = 2'sd1;
              end
              2'd3: begin
                cur_col_d = CW'(base_col_q) + CW'({1'b0, span_q}) - CW'(1);
                cnt_d     = hgt_q;
                dc_d      = 1'b0;
                dr_d      = 2'sd1;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
        state_d = rsd_pkg::S_RUN;
      end

      rsd_pkg::S_RUN: begin
        if (cnt_q == 8'd0) begin
          if ((kind_q == rsd_pkg::KIND_RECT) && (seg_q != 2'd3)) begin
            seg_d   = seg_q + 2'd1;
            state_d = rsd_pkg::S_LOAD;
          end else begin
            state_d = rsd_pkg::S_DONE;
          end
        end else begin
          cur_col_d = cur_col_q + CW'({1'b0, dc_q});
          cur_row_d = cur_row_q + CW'(dr_q);
          cnt_d     = cnt_q - 8'd1;
        end
      end

      rsd_pkg::S_DISC: begin
        if (dx_q == rad_pos) begin
          if (dy_q == rad_pos) begin
            state_d = rsd_pkg::S_DONE;
          end else begin
            dx_d = -rad_pos;
            dy_d = dy_q + 7'sd1;
          end
        end else begin
          dx_d = dx_q + 7'sd1;
        end
      end

      rsd_pkg::S_FILL: begin
        if (fill_q == rsd_pkg::FILL_LAST) begin
          state_d = rsd_pkg::S_DONE;
        end else begin
          fill_d = fill_q + AW'(1);
        end
      end

      rsd_pkg::S_READ: begin
        res_value_d = res_valid_q ? rd_data_q : 8'd0;
        state_d     = rsd_pkg::S_DONE;
      end

      rsd_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_cvalid_d = res_valid_q;
          state_d      = rsd_pkg::S_IDLE;
        end
      end

      default: state_d = rsd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    sym_q        <= sym_d;
    base_col_q   <= base_col_d;
    base_row_q   <= base_row_d;
    span_q       <= span_d;
    hgt_q        <= hgt_d;
    seg_q        <= seg_d;
    cur_col_q    <= cur_col_d;
    cur_row_q    <= cur_row_d;
    cnt_q        <= cnt_d;
    dc_q         <= dc_d;
    dr_q         <= dr_d;
    dx_q         <= dx_d;
    dy_q         <= dy_d;
    rad_q        <= rad_d;
    rsq_q        <= rsq_d;
    fill_q       <= fill_d;
    res_value_q  <= res_value_d;
    res_valid_q  <= res_valid_d;
    out_value_q  <= out_value_d;
    out_cvalid_q <= out_cvalid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_cvalid_q;

  // ---- assertions ----
  `RSD_ASSERT_IMP(a_no_write_when_ready, clk_i, rst_ni, mem_wr_en, !s_axis_tready,
                  "cell write while accepting a command")
  `RSD_ASSERT_IMP(a_shape_write_clipped, clk_i, rst_ni,
                  mem_wr_en && (state_q != rsd_pkg::S_FILL), pt_inside,
                  "shape write outside the image")
  `RSD_ASSERT_NXT(a_read_issues, clk_i, rst_ni,
                  in_accept && (in_kind == rsd_pkg::KIND_READ),
                  state_q == rsd_pkg::S_READ, "read command did not enter read state")
  `RSD_ASSERT_NXT(a_fill_ends, clk_i, rst_ni,
                  (state_q == rsd_pkg::S_FILL) && (fill_q == rsd_pkg::FILL_LAST),
                  state_q == rsd_pkg::S_DONE, "fill sweep overran")
  `RSD_ASSERT_IMP(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q),
                  $past(state_q == rsd_pkg::S_DONE),
                  "result appeared without a finished command")

endmodule

`default_nettype wire
